FILE: rtl/core/fpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants of the view frustum point test.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // fixed widths of the channel fields and config registers
  localparam int FIELD_W     = 21;
  localparam int DIR_W       = 16;
  localparam int SCALE_W     = 16;
  localparam int SCALE_FRAC  = 12;
  localparam int EYE_W       = 63;
  localparam int DIRS_W      = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STEP_W      = 5;

  localparam logic [FIELD_W-1:0] FAR_RESET   = 21'h0FFFFF;
  localparam logic [SCALE_W-1:0] SCALE_ONE   = 16'h1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EYE_POSITION = 3'd0,
    REG_FORWARD_DIR  = 3'd1,
    REG_UP_DIR       = 3'd2,
    REG_NEAR_DIST    = 3'd3,
    REG_FAR_DIST     = 3'd4,
    REG_TAN_HALF_FOV = 3'd5,
    REG_ASPECT_RATIO = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [EYE_W-1:0]   eye_position;
    logic [DIRS_W-1:0]  forward_dir;
    logic [DIRS_W-1:0]  up_dir;
    logic [FIELD_W-1:0] near_dist;
    logic [FIELD_W-1:0] far_dist;
    logic [SCALE_W-1:0] tan_half_fov;
    logic [SCALE_W-1:0] aspect_ratio;
  } cfg_t;

  // one multiply-accumulate pass each; the _B steps subtract
  typedef enum logic [STEP_W-1:0] {
    ST_RX_A = 5'd0,
    ST_RX_B = 5'd1,
    ST_RY_A = 5'd2,
    ST_RY_B = 5'd3,
    ST_RZ_A = 5'd4,
    ST_RZ_B = 5'd5,
    ST_PF_X = 5'd6,
    ST_PF_Y = 5'd7,
    ST_PF_Z = 5'd8,
    ST_PU_X = 5'd9,
    ST_PU_Y = 5'd10,
    ST_PU_Z = 5'd11,
    ST_H    = 5'd12,
    ST_PR_X = 5'd13,
    ST_PR_Y = 5'd14,
    ST_PR_Z = 5'd15,
    ST_W    = 5'd16
  } step_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_ISSUE = 2'd1,
    SEQ_DRAIN = 2'd2,
    SEQ_DONE  = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  negate;
    logic  scale;
    step_e step;
  } mac_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic hit;
  } seq_stat_t;

endpackage

FILE: rtl/core/fpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_if
// Point, result and config channels of the view frustum point test.
// ----------------------------------------------------------------------------
interface fpc_point_if import fpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic signed [FIELD_W-1:0] point_z;
  logic                      last_of_list;

  modport source (output valid, point_x, point_y, point_z, last_of_list, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_of_list, output ready);
endinterface

interface fpc_result_if ();
  logic valid;
  logic ready;
  logic point_inside;
  logic list_overlaps;
  logic end_of_list;

  modport source (output valid, point_inside, list_overlaps, end_of_list, input ready);
  modport sink   (input valid, point_inside, list_overlaps, end_of_list, output ready);
endinterface

interface fpc_cfg_if import fpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_cfg_regs
// Frustum configuration registers, written one word at a time.
// ----------------------------------------------------------------------------
module fpc_cfg_regs import fpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpc_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_EYE_POSITION: cfg_d.eye_position = cfg_i.data[EYE_W-1:0];
        REG_FORWARD_DIR:  cfg_d.forward_dir  = cfg_i.data[DIRS_W-1:0];
        REG_UP_DIR:       cfg_d.up_dir       = cfg_i.data[DIRS_W-1:0];
        REG_NEAR_DIST:    cfg_d.near_dist    = cfg_i.data[FIELD_W-1:0];
        REG_FAR_DIST:     cfg_d.far_dist     = cfg_i.data[FIELD_W-1:0];
        REG_TAN_HALF_FOV: cfg_d.tan_half_fov = cfg_i.data[SCALE_W-1:0];
        REG_ASPECT_RATIO: cfg_d.aspect_ratio = cfg_i.data[SCALE_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye_position <= '0;
      cfg_q.forward_dir  <= '0;
      cfg_q.up_dir       <= '0;
      cfg_q.near_dist    <= '0;
      cfg_q.far_dist     <= FAR_RESET;
      cfg_q.tan_half_fov <= SCALE_ONE;
      cfg_q.aspect_ratio <= SCALE_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/fpc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_mac
// Shared signed multiplier and rounding accumulator.
// ----------------------------------------------------------------------------
module fpc_mac import fpc_pkg::*; #(
  parameter int COORD_WIDTH   = 21,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mac_ctl_t                               ctl_i,
  input  logic signed [COORD_WIDTH+22-DIR_FRAC_BITS-1:0] a_i,
  input  logic signed [2*DIR_W+2-DIR_FRAC_BITS-1:0]      b_i,
  output mac_ctl_t                               tag_o,
  output logic signed [2*DIR_W+COORD_WIDTH+26-2*DIR_FRAC_BITS-1:0] res_o
);

  localparam int RW    = 2 * DIR_W + 2 - DIR_FRAC_BITS;
  localparam int PF_W  = COORD_WIDTH + DIR_W + 1 - DIR_FRAC_BITS;
  localparam int H_W   = PF_W + SCALE_W + 1 - SCALE_FRAC;
  localparam int AW    = H_W;
  localparam int BW    = RW;
  localparam int PW    = AW + BW;
  localparam int ACC_W = PW + 2;

  localparam logic signed [ACC_W-1:0] HALF_DIR   = ACC_W'(1) <<< (DIR_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_SCALE = ACC_W'(1) <<< (SCALE_FRAC - 1);

  mac_ctl_t                 ctl_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, base, prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  // a new sum starts from half an output LSB, so the shift below rounds
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    if (ctl_q.first) begin
      base = ctl_q.scale ? HALF_SCALE : HALF_DIR;
    end else begin
      base = acc_q;
    end
    acc_d = ctl_q.negate ? (base - prod_ext) : (base + prod_ext);
    res_o = ctl_q.scale ? (acc_d >>> SCALE_FRAC) : (acc_d >>> DIR_FRAC_BITS);
  end

  assign tag_o = ctl_q;

endmodule

FILE: rtl/core/fpc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_seq
// Step sequencer: offsets, operand selection, partial results and verdict.
// ----------------------------------------------------------------------------
module fpc_seq import fpc_pkg::*; #(
  parameter int COORD_WIDTH   = 21,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cfg_t                                   cfg_i,
  input  logic                                   start_i,
  input  logic                                   take_i,
  input  logic signed [FIELD_W-1:0]              point_x_i,
  input  logic signed [FIELD_W-1:0]              point_y_i,
  input  logic signed [FIELD_W-1:0]              point_z_i,
  output mac_ctl_t                               ctl_o,
  output logic signed [COORD_WIDTH+22-DIR_FRAC_BITS-1:0] a_o,
  output logic signed [2*DIR_W+2-DIR_FRAC_BITS-1:0]      b_o,
  input  mac_ctl_t                               tag_i,
  input  logic signed [2*DIR_W+COORD_WIDTH+26-2*DIR_FRAC_BITS-1:0] res_i,
  output seq_stat_t                              stat_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int RW    = 2 * DIR_W + 2 - DIR_FRAC_BITS;
  localparam int PF_W  = CW + DIR_W + 1 - DIR_FRAC_BITS;
  localparam int H_W   = PF_W + SCALE_W + 1 - SCALE_FRAC;
  localparam int W_W   = H_W + SCALE_W + 1 - SCALE_FRAC;
  localparam int PR_W  = CW + RW + 1 - DIR_FRAC_BITS;
  localparam int AW    = H_W;
  localparam int BW    = RW;
  localparam int CMP_W = ((PR_W > W_W) ? PR_W : W_W) + 1;

  localparam logic signed [CW-1:0] V_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] V_MIN = {1'b1, {(CW-1){1'b0}}};

  seq_state_e state_q, state_d;
  step_e      step_q, step_d;

  logic signed [CW-1:0]    v_q  [3];
  logic signed [CW-1:0]    v_d  [3];
  logic signed [CW:0]      diff [3];
  logic signed [FIELD_W-1:0] pt [3];
  logic signed [DIR_W-1:0] fd   [3];
  logic signed [DIR_W-1:0] ud   [3];
  logic signed [RW-1:0]    r_q  [3];
  logic signed [PF_W-1:0]  pf_q, pu_q;
  logic signed [PR_W-1:0]  pr_q;
  logic signed [H_W-1:0]   h_q;
  logic signed [W_W-1:0]   w_q;

  logic signed [PF_W-1:0]  near_s, far_s;
  logic signed [H_W:0]     pu_e, h_e, h_neg;
  logic signed [CMP_W-1:0] pr_e, w_e, w_neg;
  logic                    in_depth, in_height, in_width;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // offsets from the eye, saturated to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (CW+1)'(signed'(pt[i][CW-1:0]))
              - (CW+1)'(signed'(cfg_i.eye_position[FIELD_W*i +: CW]));
      if (diff[i][CW] != diff[i][CW-1]) begin
        v_d[i] = diff[i][CW] ? V_MIN : V_MAX;
      end else begin
        v_d[i] = diff[i][CW-1:0];
      end
      fd[i] = signed'(cfg_i.forward_dir[DIR_W*i +: DIR_W]);
      ud[i] = signed'(cfg_i.up_dir[DIR_W*i +: DIR_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= ST_RX_A;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_ISSUE;
          step_d  = ST_RX_A;
        end
      end
      SEQ_ISSUE: begin
        if (step_q == ST_W) begin
          state_d = SEQ_DRAIN;
        end else begin
          step_d = step_e'(step_q + 1'b1);
        end
      end
      SEQ_DRAIN: state_d = SEQ_DONE;
      SEQ_DONE: begin
        if (take_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // control outputs of the current state
  always_comb begin
    stat_o.idle   = (state_q == SEQ_IDLE);
    stat_o.done   = (state_q == SEQ_DONE);
    stat_o.hit    = in_depth && in_height && in_width;
    ctl_o.valid   = (state_q == SEQ_ISSUE);
    ctl_o.step    = step_q;
    ctl_o.first   = 1'b0;
    ctl_o.negate  = 1'b0;
    ctl_o.scale   = 1'b0;
    case (step_q)
      ST_RX_A, ST_RY_A, ST_RZ_A, ST_PF_X, ST_PU_X, ST_PR_X: ctl_o.first = 1'b1;
      ST_RX_B, ST_RY_B, ST_RZ_B:                            ctl_o.negate = 1'b1;
      ST_H, ST_W: begin
        ctl_o.first = 1'b1;
        ctl_o.scale = 1'b1;
      end
      default: ;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (step_q)
      ST_RX_A: begin a_o = AW'(fd[1]);   b_o = BW'(ud[2]); end
      ST_RX_B: begin a_o = AW'(fd[2]);   b_o = BW'(ud[1]); end
      ST_RY_A: begin a_o = AW'(fd[2]);   b_o = BW'(ud[0]); end
      ST_RY_B: begin a_o = AW'(fd[0]);   b_o = BW'(ud[2]); end
      ST_RZ_A: begin a_o = AW'(fd[0]);   b_o = BW'(ud[1]); end
      ST_RZ_B: begin a_o = AW'(fd[1]);   b_o = BW'(ud[0]); end
      ST_PF_X: begin a_o = AW'(v_q[0]);  b_o = BW'(fd[0]); end
      ST_PF_Y: begin a_o = AW'(v_q[1]);  b_o = BW'(fd[1]); end
      ST_PF_Z: begin a_o = AW'(v_q[2]);  b_o = BW'(fd[2]); end
      ST_PU_X: begin a_o = AW'(v_q[0]);  b_o = BW'(ud[0]); end
      ST_PU_Y: begin a_o = AW'(v_q[1]);  b_o = BW'(ud[1]); end
      ST_PU_Z: begin a_o = AW'(v_q[2]);  b_o = BW'(ud[2]); end
      ST_H:    begin a_o = AW'(pf_q);    b_o = BW'(cfg_i.tan_half_fov); end
      ST_PR_X: begin a_o = AW'(v_q[0]);  b_o = BW'(r_q[0]); end
      ST_PR_Y: begin a_o = AW'(v_q[1]);  b_o = BW'(r_q[1]); end
      ST_PR_Z: begin a_o = AW'(v_q[2]);  b_o = BW'(r_q[2]); end
      ST_W:    begin a_o = AW'(h_q);     b_o = BW'(cfg_i.aspect_ratio); end
      default: begin a_o = '0;           b_o = '0; end
    endcase
  end

  // hold the offsets and capture each finished sum
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SEQ_IDLE)) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= v_d[i];
      end
    end
    if (tag_i.valid) begin
      case (tag_i.step)
        ST_RX_B: r_q[0] <= res_i[RW-1:0];
        ST_RY_B: r_q[1] <= res_i[RW-1:0];
        ST_RZ_B: r_q[2] <= res_i[RW-1:0];
        ST_PF_Z: pf_q   <= res_i[PF_W-1:0];
        ST_PU_Z: pu_q   <= res_i[PF_W-1:0];
        ST_H:    h_q    <= res_i[H_W-1:0];
        ST_PR_Z: pr_q   <= res_i[PR_W-1:0];
        ST_W:    w_q    <= res_i[W_W-1:0];
        default: ;
      endcase
    end
  end

  // inclusive bounds; a negative half-height or half-width rejects everything
  always_comb begin
    near_s    = PF_W'(signed'(cfg_i.near_dist[CW-1:0]));
    far_s     = PF_W'(signed'(cfg_i.far_dist[CW-1:0]));
    pu_e      = (H_W+1)'(pu_q);
    h_e       = (H_W+1)'(h_q);
    h_neg     = -h_e;
    pr_e      = CMP_W'(pr_q);
    w_e       = CMP_W'(w_q);
    w_neg     = -w_e;
    in_depth  = (pf_q >= near_s) && (pf_q <= far_s);
    in_height = (pu_e <= h_e) && (pu_e >= h_neg);
    in_width  = (pr_e <= w_e) && (pr_e >= w_neg);
  end

endmodule

FILE: rtl/core/frustum_point_containment_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_point_containment_top
// Tests 3D points against a view frustum and tracks a per-list hit flag.
// ----------------------------------------------------------------------------
// Each point is accepted in the idle state and then makes 17 passes through
// the single shared multiply-accumulate unit (right axis, three projections,
// half-height and half-width); a drain state finishes the last sum and the
// done state hands the verdict to the result register. point_i.ready is high
// only while the sequencer is idle. The result register lets the next point
// enter while the previous verdict still waits to be taken. Config words are
// always taken (cfg_i.ready is tied high) and must be written only while idle.
module frustum_point_containment_top import fpc_pkg::*; #(
  parameter int COORD_WIDTH   = 21,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fpc_cfg_if.sink        cfg_i,
  fpc_point_if.sink      point_i,
  fpc_result_if.source   result_o
);

  localparam int AW    = COORD_WIDTH + 22 - DIR_FRAC_BITS;
  localparam int BW    = 2 * DIR_W + 2 - DIR_FRAC_BITS;
  localparam int ACC_W = AW + BW + 2;

  cfg_t                    cfg;
  mac_ctl_t                ctl, tag;
  seq_stat_t               stat;
  logic signed [AW-1:0]    mac_a;
  logic signed [BW-1:0]    mac_b;
  logic signed [ACC_W-1:0] mac_res;

  logic accept, take;
  logic last_q;
  logic any_q, any_d;
  logic out_valid_q, out_inside_q, out_overlaps_q, out_eol_q;

  fpc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fpc_seq #(
    .COORD_WIDTH   (COORD_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .start_i   (accept),
    .take_i    (take),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .point_z_i (point_i.point_z),
    .ctl_o     (ctl),
    .a_o       (mac_a),
    .b_o       (mac_b),
    .tag_i     (tag),
    .res_i     (mac_res),
    .stat_o    (stat)
  );

  fpc_mac #(
    .COORD_WIDTH   (COORD_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .tag_o  (tag),
    .res_o  (mac_res)
  );

  assign point_i.ready = stat.idle;
  assign accept        = point_i.valid && point_i.ready;
  // load the result register when it is empty or its word is leaving
  assign take          = stat.done && (!out_valid_q || result_o.ready);
  assign any_d         = any_q || stat.hit;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= point_i.last_of_list;
    end
    if (take) begin
      out_inside_q   <= stat.hit;
      out_overlaps_q <= any_d;
      out_eol_q      <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        any_q       <= last_q ? 1'b0 : any_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.point_inside  = out_inside_q;
  assign result_o.list_overlaps = out_overlaps_q;
  assign result_o.end_of_list   = out_eol_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !point_i.ready)
    else $error("point accepted while a previous point is still in work");

  a_flag_cleared_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_q) |=> !any_q)
    else $error("list flag not cleared after last point");

  a_overlap_covers_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.point_inside) |-> result_o.list_overlaps)
    else $error("inside point not reflected in list flag");

  a_take_only_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (point_i.ready && out_valid_q))
    else $error("verdict handoff did not release sequencer");

endmodule
